// ----- hdl/ostt_pkg.sv -----
package ostt_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int FW = $clog2(MAX_RESULTS + 1);
	localparam logic [31:0] FIRST_HANDLE = 32'h1;

	// command codes
	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_RESTART = 3'd1;
	localparam logic [2:0] CMD_CANCEL  = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;
	localparam logic [2:0] CMD_QUERY   = 3'd5;

	// microprogram addresses
	localparam int UAW = 3;
	typedef logic [UAW-1:0] uaddr_t;
	localparam uaddr_t UA_IDLE   = 3'd0;
	localparam uaddr_t UA_TICK   = 3'd1;
	localparam uaddr_t UA_SCAN   = 3'd2;
	localparam uaddr_t UA_DRAIN  = 3'd3;
	localparam uaddr_t UA_ARM    = 3'd4;
	localparam uaddr_t UA_FLUSH  = 3'd5;
	localparam uaddr_t UA_RESULT = 3'd6;

	// jump conditions
	localparam logic [1:0] C_ALWAYS  = 2'd0;
	localparam logic [1:0] C_START   = 2'd1;
	localparam logic [1:0] C_ENABLED = 2'd2;
	localparam logic [1:0] C_MORE    = 2'd3;

	// dispatch selection for the taken branch
	localparam logic [1:0] D_NONE   = 2'd0;
	localparam logic [1:0] D_ENTRY  = 2'd1;
	localparam logic [1:0] D_FINISH = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] delay_ms;
		logic [31:0] handle_in;
		logic [31:0] check_time;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [31:0]        handle_out;
		logic               fired;
		logic [31:0]        time_now;
		logic signed [31:0] remaining;
		logic               elapsed;
		logic               last;
	} res_t;

	typedef struct packed {
		logic       accept;
		logic       tick_inc;
		logic       rd;
		logic       ev;
		logic       arm;
		logic       emit_one;
		logic       flush;
		logic [1:0] cond;
		logic [1:0] disp;
		uaddr_t     t_addr;
		uaddr_t     f_addr;
	} ctl_t;

	typedef struct packed {
		logic       enabled;
		logic       more;
		logic [2:0] cmd;
	} stat_t;

	function automatic ctl_t ucode_rom(input uaddr_t a);
		ctl_t c;
		c = '0;
		case (a)
			UA_IDLE: begin
				c.accept = 1'b1;
				c.cond   = C_START;
				c.disp   = D_ENTRY;
				c.f_addr = UA_IDLE;
			end
			UA_TICK: begin
				c.tick_inc = 1'b1;
				c.cond     = C_ENABLED;
				c.t_addr   = UA_SCAN;
				c.f_addr   = UA_RESULT;
			end
			UA_SCAN: begin
				c.rd     = 1'b1;
				c.ev     = 1'b1;
				c.cond   = C_MORE;
				c.t_addr = UA_SCAN;
				c.f_addr = UA_DRAIN;
			end
			UA_DRAIN: begin
				c.ev   = 1'b1;
				c.cond = C_ALWAYS;
				c.disp = D_FINISH;
			end
			UA_ARM: begin
				c.arm    = 1'b1;
				c.cond   = C_ALWAYS;
				c.t_addr = UA_IDLE;
			end
			UA_FLUSH: begin
				c.flush  = 1'b1;
				c.cond   = C_ALWAYS;
				c.t_addr = UA_IDLE;
			end
			UA_RESULT: begin
				c.emit_one = 1'b1;
				c.cond     = C_ALWAYS;
				c.t_addr   = UA_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.t_addr = UA_IDLE;
			end
		endcase
		return c;
	endfunction

	function automatic uaddr_t entry_tgt(input logic [2:0] cmd);
		uaddr_t t;
		case (cmd)
			CMD_START, CMD_RESTART, CMD_CANCEL: t = UA_SCAN;
			CMD_TICK:                           t = UA_TICK;
			default:                            t = UA_RESULT;
		endcase
		return t;
	endfunction

	function automatic uaddr_t finish_tgt(input logic [2:0] cmd);
		uaddr_t t;
		case (cmd)
			CMD_START, CMD_RESTART: t = UA_ARM;
			CMD_TICK:               t = UA_FLUSH;
			default:                t = UA_RESULT;
		endcase
		return t;
	endfunction

endpackage

// ----- hdl/one_shot_timer_table.sv -----
// Sequence: start, restart and cancel give their word after the slot scan and drain, a tick
// after its tick step, scan and drain, or after the tick step alone while ticks are disabled
// (expired handles stream out during the slot scan); read time and query go straight to the result.
// Throughput: one command at a time; busy stays high while the microprogram runs and
// the slot scan reads one handle/deadline entry per cycle from the slot memories.
// Each result word is shown for one cycle on result_stb; the receiver cannot stall.
// Reset: arst_n clears all slots, the tick count and user count, next handle to 1.
module one_shot_timer_table import ostt_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output res_t result,
	output logic result_stb
);

	ctl_t  ctl;
	stat_t st;

	ostt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_cmd (req.command),
		.st      (st),
		.ctl     (ctl),
		.busy    (busy)
	);

	ostt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.ctl        (ctl),
		.st         (st),
		.result     (result),
		.result_stb (result_stb)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not start the sequencer");

	a_fired_handle: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && result.fired |-> result.handle_out != 32'd0 && !result.status)
		else $error("expiry reported without a handle");

	a_elapsed_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && result.elapsed |-> result.remaining[31] || result.remaining == 32'sd0)
		else $error("elapsed flag disagrees with remaining time");

	a_status_arm: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && result.status |-> result.handle_out == 32'd0 && result.last)
		else $error("failed start carried a handle");

endmodule

// ----- hdl/ostt_seq.sv -----
module ostt_seq import ostt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] req_cmd,
	input  stat_t      st,
	output ctl_t       ctl,
	output logic       busy
);

	uaddr_t upc_q;
	uaddr_t tgt;
	logic   cond_ok;

	assign ctl  = ucode_rom(upc_q);
	assign busy = (upc_q != UA_IDLE);

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:  cond_ok = 1'b1;
			C_START:   cond_ok = start;
			C_ENABLED: cond_ok = st.enabled;
			C_MORE:    cond_ok = st.more;
			default:   cond_ok = 1'b1;
		endcase
		case (ctl.disp)
			D_ENTRY:  tgt = entry_tgt(req_cmd);
			D_FINISH: tgt = finish_tgt(st.cmd);
			default:  tgt = ctl.t_addr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= cond_ok ? tgt : ctl.f_addr;
		end
	end

endmodule

// ----- hdl/ostt_dp.sv -----
module ostt_dp import ostt_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	input  ctl_t  ctl,
	output stat_t st,
	output res_t  result,
	output logic  result_stb
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] TOP_IDX = IW'(SLOTS - 1);

	req_t            req_q;
	logic [IW-1:0]   idx_q;
	logic            rd_s1;
	logic [IW-1:0]   idx_s1;
	logic [31:0]     hdl_s1;
	logic [31:0]     dl_s1;
	logic [SLOTS-1:0] valid_q;
	logic [31:0]     hdl_mem [SLOTS];
	logic [31:0]     dl_mem  [SLOTS];
	logic [31:0]     tick_q;
	logic [31:0]     next_q;
	logic [31:0]     user_q;
	logic            en_q;
	logic            free_found_q;
	logic [IW-1:0]   free_idx_q;
	logic            hit_found_q;
	logic [IW-1:0]   hit_idx_q;
	logic [FW-1:0]   nfire_q;
	logic            pend_q;
	logic [31:0]     pend_hdl_q;
	res_t            res_q;
	logic            stb_q;

	logic            acc;
	logic            ev_now;
	logic            v_s1;
	logic            is_find;
	logic            cancel_hit;
	logic            expire;
	logic            release_now;
	logic            free_now;
	logic            hit_now;
	logic            arm_ok;
	logic [IW-1:0]   arm_idx;
	logic [31:0]     next_inc;
	logic [31:0]     next_nx;
	logic [31:0]     rem;
	res_t            res_nx;
	logic            stb_nx;

	assign acc     = ctl.accept & start;
	assign ev_now  = ctl.ev & rd_s1;
	assign v_s1    = valid_q[idx_s1];
	assign is_find = req_q.command inside {CMD_START, CMD_RESTART};

	assign cancel_hit = ev_now && (req_q.command == CMD_CANCEL) && v_s1
		&& (hdl_s1 == req_q.handle_in);
	assign expire = ev_now && (req_q.command == CMD_TICK) && v_s1 && (dl_s1 == tick_q)
		&& (nfire_q < FW'(MAX_RESULTS));
	assign release_now = cancel_hit | expire;
	assign free_now = ev_now && is_find && !v_s1 && !free_found_q;
	assign hit_now  = ev_now && (req_q.command == CMD_RESTART) && (req_q.handle_in != '0)
		&& v_s1 && (hdl_s1 == req_q.handle_in) && !hit_found_q;

	assign arm_ok   = hit_found_q | free_found_q;
	assign arm_idx  = hit_found_q ? hit_idx_q : free_idx_q;
	assign next_inc = next_q + 32'd1;
	assign next_nx  = (next_inc == '0) ? FIRST_HANDLE : next_inc;
	assign rem      = req_q.check_time - tick_q;

	assign st.enabled = en_q;
	assign st.more    = (idx_q != '0);
	assign st.cmd     = req_q.command;

	always_comb begin
		res_nx            = '0;
		res_nx.time_now   = tick_q;
		stb_nx            = 1'b0;
		if (expire && pend_q) begin
			// a newer expiry proves the held one is not the final word
			stb_nx            = 1'b1;
			res_nx.handle_out = pend_hdl_q;
			res_nx.fired      = 1'b1;
		end else if (ctl.arm) begin
			stb_nx            = 1'b1;
			res_nx.status     = !arm_ok;
			res_nx.handle_out = arm_ok ? next_q : 32'd0;
			res_nx.last       = 1'b1;
		end else if (ctl.flush) begin
			stb_nx            = 1'b1;
			res_nx.handle_out = pend_q ? pend_hdl_q : 32'd0;
			res_nx.fired      = pend_q;
			res_nx.last       = 1'b1;
		end else if (ctl.emit_one) begin
			stb_nx = 1'b1;
			if (req_q.command == CMD_QUERY) begin
				res_nx.remaining = rem;
				res_nx.elapsed   = (rem == '0) || rem[31];
			end
			res_nx.last = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_s1        <= 1'b0;
			valid_q      <= '0;
			tick_q       <= '0;
			next_q       <= FIRST_HANDLE;
			user_q       <= '0;
			en_q         <= 1'b1;
			free_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			nfire_q      <= '0;
			pend_q       <= 1'b0;
			stb_q        <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd;
			stb_q <= stb_nx;
			if (acc) begin
				idx_q        <= TOP_IDX;
				free_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
				nfire_q      <= '0;
				pend_q       <= 1'b0;
			end
			if (ctl.rd && idx_q != '0) begin
				idx_q <= idx_q - IW'(1);
			end
			if (ctl.tick_inc && en_q) begin
				tick_q <= tick_q + 32'd1;
			end
			if (free_now) begin
				free_found_q <= 1'b1;
			end
			if (hit_now) begin
				hit_found_q <= 1'b1;
			end
			if (release_now) begin
				valid_q[idx_s1] <= 1'b0;
				if (user_q != '0) begin
					user_q <= user_q - 32'd1;
					if (user_q == 32'd1) begin
						en_q <= 1'b0;
					end
				end
			end
			if (expire) begin
				pend_q  <= 1'b1;
				nfire_q <= nfire_q + FW'(1);
			end
			if (ctl.arm && arm_ok) begin
				valid_q[arm_idx] <= 1'b1;
				next_q           <= next_nx;
				en_q             <= 1'b1;
				if (!hit_found_q) begin
					user_q <= user_q + 32'd1;
				end
			end
			if (ctl.emit_one && req_q.command == CMD_READ) begin
				user_q <= user_q + 32'd1;
				en_q   <= 1'b1;
			end
		end
	end

	// payload and slot storage
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req;
		end
		if (ctl.rd) begin
			idx_s1 <= idx_q;
			hdl_s1 <= hdl_mem[idx_q];
			dl_s1  <= dl_mem[idx_q];
		end
		if (ctl.arm && arm_ok) begin
			hdl_mem[arm_idx] <= next_q;
			dl_mem[arm_idx]  <= tick_q + req_q.delay_ms;
		end
		if (free_now) begin
			free_idx_q <= idx_s1;
		end
		if (hit_now) begin
			hit_idx_q <= idx_s1;
		end
		if (expire) begin
			pend_hdl_q <= hdl_s1;
		end
		if (stb_nx) begin
			res_q <= res_nx;
		end
	end

	assign result     = res_q;
	assign result_stb = stb_q;

endmodule

// ----- dv/one_shot_timer_table_test.sv -----
`timescale 1ns / 1ps

module one_shot_timer_table_test;
	import ostt_pkg::*;

	localparam int SLOTS = 16;
	localparam int RANDOM_WORDS = 90;
	localparam int LIMIT_CYCLES = 100000;

	typedef struct {
		req_t word;
		bit   drain;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	res_t result;
	logic result_stb;

	// handoff from driver to the timer-table predictor
	logic acc_valid = 1'b0;
	req_t acc_req = '0;

	pending_t pending[$];
	res_t timer_words[$];
	int words_outstanding = 0;
	int mismatches = 0;
	int cycles = 0;
	int gap_left = 0;
	bit idle_on = 1'b1;

	// predicted table state
	logic [31:0] timer_handle[SLOTS];
	logic [31:0] timer_deadline[SLOTS];
	logic [31:0] now_ticks;
	logic [31:0] handle_seq;
	logic [31:0] holders;
	bit ticking;

	one_shot_timer_table #(.SLOTS(SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result(result),
		.result_stb(result_stb)
	);

	always #4 clk = ~clk;

	function automatic void release_holder();
		if (holders != 0) begin
			holders--;
			if (holders == 0)
				ticking = 1'b0;
		end
	endfunction

	function automatic logic [31:0] arm_timer(int s, logic [31:0] delay, bit fresh);
		logic [31:0] h;
		h = handle_seq;
		ticking = 1'b1;
		if (fresh)
			holders++;
		timer_deadline[s] = now_ticks + delay;
		timer_handle[s] = h;
		handle_seq++;
		if (handle_seq == 0)
			handle_seq = FIRST_HANDLE;
		return h;
	endfunction

	function automatic int slot_holding(logic [31:0] h);
		for (int s = SLOTS - 1; s >= 0; s--)
			if (timer_handle[s] == h)
				return s;
		return -1;
	endfunction

	function automatic void predict_timer_words(req_t r);
		res_t w;
		int s;
		int n;
		n = 0;
		w = '0;
		case (r.command)
			CMD_START, CMD_RESTART: begin
				s = (r.command == CMD_RESTART && r.handle_in != 0) ?
					slot_holding(r.handle_in) : -1;
				if (s >= 0) begin
					w.handle_out = arm_timer(s, r.delay_ms, 1'b0);
				end else begin
					s = slot_holding('0);
					if (s >= 0)
						w.handle_out = arm_timer(s, r.delay_ms, 1'b1);
					else
						w.status = 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (r.handle_in != 0)
					for (s = SLOTS - 1; s >= 0; s--)
						if (timer_handle[s] == r.handle_in) begin
							release_holder();
							timer_handle[s] = '0;
						end
			end
			CMD_TICK: begin
				if (ticking) begin
					now_ticks++;
					// keep scanning even if the last holder goes away mid-scan
					for (s = SLOTS - 1; s >= 0 && n < MAX_RESULTS; s--)
						if (timer_handle[s] != 0 && timer_deadline[s] == now_ticks) begin
							w = '0;
							w.handle_out = timer_handle[s];
							w.fired = 1'b1;
							w.time_now = now_ticks;
							release_holder();
							timer_handle[s] = '0;
							timer_words.push_back(w);
							n++;
						end
					w = '0;
				end
			end
			CMD_READ: begin
				holders++;
				ticking = 1'b1;
			end
			CMD_QUERY: begin
				w.remaining = r.check_time - now_ticks;
				w.elapsed = ($signed(w.remaining) <= 0);
			end
			default: ;
		endcase
		if (n == 0) begin
			w.time_now = now_ticks;
			timer_words.push_back(w);
		end
		w = timer_words.pop_back();
		w.last = 1'b1;
		timer_words.push_back(w);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		pending_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			acc_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			acc_valid <= start && !busy;
			acc_req <= req;
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending.size() != 0 && (!pending[0].drain ||
						(!start && !acc_valid && !busy && words_outstanding == 0))) begin
					nxt = pending.pop_front();
					req <= nxt.word;
					start <= 1'b1;
					gap_left <= (idle_on && $urandom_range(0, 2) == 0) ?
						$urandom_range(1, 15) : 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: predict accepted words, then check the result port
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				timer_handle[s] = '0;
				timer_deadline[s] = '0;
			end
			now_ticks = '0;
			handle_seq = FIRST_HANDLE;
			holders = '0;
			ticking = 1'b1;
			timer_words.delete();
			words_outstanding <= 0;
		end else begin
			if (acc_valid)
				predict_timer_words(acc_req);
			if (result_stb) begin
				if (timer_words.size() == 0) begin
					$error("unexpected result word: handle_out %0h", result.handle_out);
					mismatches++;
				end else begin
					want = timer_words.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mismatches++;
					end
					if (result.handle_out !== want.handle_out) begin
						$error("handle_out: expected %0h, got %0h",
							want.handle_out, result.handle_out);
						mismatches++;
					end
					if (result.fired !== want.fired) begin
						$error("fired: expected %0d, got %0d", want.fired, result.fired);
						mismatches++;
					end
					if (result.time_now !== want.time_now) begin
						$error("time_now: expected %0h, got %0h", want.time_now, result.time_now);
						mismatches++;
					end
					if (result.remaining !== want.remaining) begin
						$error("remaining: expected %0d, got %0d",
							want.remaining, result.remaining);
						mismatches++;
					end
					if (result.elapsed !== want.elapsed) begin
						$error("elapsed: expected %0d, got %0d", want.elapsed, result.elapsed);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						mismatches++;
					end
				end
			end
			words_outstanding <= timer_words.size();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_word(logic [2:0] cmd, logic [31:0] delay, logic [31:0] hnd,
			logic [31:0] chk, bit drain);
		pending_t p;
		while (pending.size() != 0)
			@(negedge clk);
		p.word.command = cmd;
		p.word.delay_ms = delay;
		p.word.handle_in = hnd;
		p.word.check_time = chk;
		p.drain = drain;
		pending.push_back(p);
	endtask

	function automatic logic [31:0] live_handle();
		logic [31:0] found[SLOTS];
		int n;
		n = 0;
		for (int s = 0; s < SLOTS; s++)
			if (timer_handle[s] != 0) begin
				found[n] = timer_handle[s];
				n++;
			end
		if (n == 0)
			return $urandom;
		return found[$urandom_range(0, n - 1)];
	endfunction

	initial begin
		int pick;
		logic [31:0] delay;
		logic [31:0] chk;
		logic [31:0] hnd;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fire the only holder, then a tick while disabled, then re-enable
		queue_word(CMD_START, 32'd1, $urandom, $urandom, 1'b0);
		queue_word(CMD_TICK, $urandom, $urandom, $urandom, 1'b0);
		queue_word(CMD_TICK, $urandom, $urandom, $urandom, 1'b0);
		queue_word(CMD_READ, $urandom, $urandom, $urandom, 1'b0);
		queue_word(CMD_QUERY, 32'd0, 32'd0, 32'h0000_0000, 1'b0);
		queue_word(CMD_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
		queue_word(CMD_QUERY, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0);
		queue_word(CMD_QUERY, 32'd0, 32'd0, 32'h8000_0000, 1'b0);
		// handles 2, 3 and 4
		queue_word(CMD_START, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_word(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_word(CMD_START, 32'd2, 32'd0, 32'd0, 1'b0);
		// re-arm a live handle, then restarts that fall back to a fresh slot
		queue_word(CMD_RESTART, 32'd1, 32'd2, 32'd0, 1'b0);
		queue_word(CMD_RESTART, 32'd1, 32'd0, 32'd0, 1'b0);
		queue_word(CMD_RESTART, 32'd1, 32'hDEAD_BEEF, 32'd0, 1'b0);
		// three expire together, then one more
		queue_word(CMD_TICK, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_word(CMD_TICK, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_word(CMD_CANCEL, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_word(CMD_CANCEL, 32'd0, 32'd3, 32'd0, 1'b0);
		queue_word(CMD_CANCEL, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
		queue_word(3'd6, $urandom, $urandom, $urandom, 1'b0);
		queue_word(3'd7, $urandom, $urandom, $urandom, 1'b0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			idle_on = (i < RANDOM_WORDS - 25);
			pick = $urandom_range(0, 99);
			// crowd the table so starts run out of free slots
			if (i >= 20 && i < 45 && pick < 60)
				pick = 0;
			case ($urandom_range(0, 9))
				0: delay = $urandom;
				1: delay = 32'd0;
				default: delay = $urandom_range(1, 6);
			endcase
			chk = $urandom;
			hnd = $urandom_range(0, 1) ? 32'd0 : $urandom;
			if (pick < 30) begin
				queue_word(CMD_START, delay, $urandom, chk, i == 0 || $urandom_range(0, 19) == 0);
			end else if (pick < 40) begin
				queue_word(CMD_RESTART, delay, live_handle(), chk, 1'b0);
			end else if (pick < 45) begin
				queue_word(CMD_RESTART, delay, hnd, chk, 1'b0);
			end else if (pick < 55) begin
				queue_word(CMD_CANCEL, delay, live_handle(), chk, $urandom_range(0, 9) == 0);
			end else if (pick < 58) begin
				queue_word(CMD_CANCEL, delay, hnd, chk, 1'b0);
			end else if (pick < 85) begin
				queue_word(CMD_TICK, delay, $urandom, chk, 1'b0);
			end else if (pick < 90) begin
				queue_word(CMD_READ, delay, $urandom, chk, 1'b0);
			end else if (pick < 97) begin
				if ($urandom_range(0, 3) != 0)
					chk = now_ticks + $urandom_range(0, 8) - 4;
				queue_word(CMD_QUERY, delay, $urandom, chk, 1'b0);
			end else begin
				queue_word($urandom_range(0, 1) ? 3'd6 : 3'd7, delay, $urandom, chk, 1'b0);
			end
		end

		while (pending.size() != 0 || start || acc_valid || busy || words_outstanding != 0)
			@(negedge clk);
		repeat (SLOTS + 10) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
